FILE: rtl/core/pgw_pkg.sv
// shared types, widths and codes for the page table walker
`timescale 1ns / 1ps

package pgw_pkg;

	// fixed field widths
	localparam int VA_W    = 48;
	localparam int ENTRY_W = 64;
	localparam int DIR_W   = 36;
	localparam int RA_W    = 36;
	localparam int PA_W    = 52;
	localparam int SIZE_W  = 2;
	localparam int LVL_W   = 2;
	localparam int IDX_W   = 9;

	// default width of a table base inside an entry
	localparam int PHYS_TABLE_BITS_DEF = 36;

	// request operation codes
	localparam logic OP_TRANSLATE = 1'b0;
	localparam logic OP_RESPONSE  = 1'b1;

	// result kinds
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// page size codes
	localparam logic [SIZE_W-1:0] PAGE_4K = 2'd0;
	localparam logic [SIZE_W-1:0] PAGE_2M = 2'd1;
	localparam logic [SIZE_W-1:0] PAGE_1G = 2'd2;

	// walk levels, top table first
	localparam logic [LVL_W-1:0] LVL_PML4 = 2'd0;
	localparam logic [LVL_W-1:0] LVL_PDPT = 2'd1;
	localparam logic [LVL_W-1:0] LVL_PD   = 2'd2;
	localparam logic [LVL_W-1:0] LVL_PT   = 2'd3;

	// entry flag positions
	localparam int PRESENT_BIT = 0;
	localparam int PS_BIT      = 7;

	// walk control state
	typedef struct packed {
		logic             busy;
		logic [LVL_W-1:0] level;
	} walk_state_t;

	// one result
	typedef struct packed {
		logic              result_kind;
		logic [RA_W-1:0]   read_address;
		logic [PA_W-1:0]   trans_addr;
		logic [SIZE_W-1:0] map_size;
		logic              fault;
	} rsp_t;

endpackage

FILE: rtl/core/pgw_if.sv
// handshake channels of the page table walker
`timescale 1ns / 1ps

// translate requests and memory read responses
interface pgw_req_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [pgw_pkg::VA_W-1:0]    virtual_address;
	logic [pgw_pkg::ENTRY_W-1:0] entry_data;
	logic                        read_error;

	modport source (output valid, operation, virtual_address, entry_data, read_error,
		input ready);
	modport sink (input valid, operation, virtual_address, entry_data, read_error,
		output ready);
endinterface

// read requests and finished walks
interface pgw_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       result_kind;
	logic [pgw_pkg::RA_W-1:0]   read_address;
	logic [pgw_pkg::PA_W-1:0]   trans_addr;
	logic [pgw_pkg::SIZE_W-1:0] map_size;
	logic                       fault;

	modport source (output valid, result_kind, read_address, trans_addr, map_size,
		fault, input ready);
	modport sink (input valid, result_kind, read_address, trans_addr, map_size,
		fault, output ready);
endinterface

// directory base register write
interface pgw_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [pgw_pkg::DIR_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: rtl/core/pgw_step.sv
// one walk step: result and next walk state for one request
`timescale 1ns / 1ps

module pgw_step #(
	parameter int PHYS_TABLE_BITS = pgw_pkg::PHYS_TABLE_BITS_DEF
) (
	input  logic                        operation,
	input  logic [pgw_pkg::VA_W-1:0]    virtual_address,
	input  logic [pgw_pkg::ENTRY_W-1:0] entry_data,
	input  logic                        read_error,
	input  pgw_pkg::walk_state_t        state,
	input  logic [pgw_pkg::VA_W-1:0]    saved_vaddr,
	input  logic [pgw_pkg::DIR_W-1:0]   dir_base,
	output pgw_pkg::walk_state_t        state_next,
	output logic                        load_vaddr,
	output pgw_pkg::rsp_t               rsp
);

	logic [pgw_pkg::ENTRY_W-1:0]  entry;
	logic [PHYS_TABLE_BITS-1:0]   dir_table;
	logic [PHYS_TABLE_BITS-1:0]   entry_table;
	logic [PHYS_TABLE_BITS-1:0]   base_sel;
	logic [PHYS_TABLE_BITS-1:0]   rd_sum;
	logic [pgw_pkg::PA_W-1:0]     dir_ext;
	logic [pgw_pkg::PA_W-1:0]     rd_ext;
	logic [pgw_pkg::IDX_W-1:0]    idx;
	logic [PHYS_TABLE_BITS-13:0]  frame_4k;
	logic                         issue;

	// failed read reads as an empty entry
	assign entry = read_error ? '0 : entry_data;

	// table bases: directory with low nibble cleared, or entry frame
	assign dir_ext     = pgw_pkg::PA_W'({dir_base[pgw_pkg::DIR_W-1:4], 4'b0000});
	assign dir_table   = dir_ext[PHYS_TABLE_BITS-1:0];
	assign frame_4k    = entry[PHYS_TABLE_BITS-1:12];
	assign entry_table = {frame_4k, 12'h000};

	// entry read address, wraps within the table address width
	assign base_sel = (operation == pgw_pkg::OP_TRANSLATE) ? dir_table : entry_table;
	assign rd_sum   = base_sel + PHYS_TABLE_BITS'({idx, 3'b000});
	assign rd_ext   = pgw_pkg::PA_W'(rd_sum);

	// index of the next table: new address for a translate, else saved one
	always_comb begin
		if (operation == pgw_pkg::OP_TRANSLATE) begin
			idx = virtual_address[47:39];
		end else begin
			case (state.level)
				pgw_pkg::LVL_PML4: idx = saved_vaddr[38:30];
				pgw_pkg::LVL_PDPT: idx = saved_vaddr[29:21];
				pgw_pkg::LVL_PD:   idx = saved_vaddr[20:12];
				default:           idx = saved_vaddr[20:12];
			endcase
		end
	end

	// walk decision
	always_comb begin
		state_next = state;
		load_vaddr = 1'b0;
		issue      = 1'b0;
		rsp        = '0;
		rsp.result_kind = pgw_pkg::KIND_DONE;

		if (operation == pgw_pkg::OP_TRANSLATE) begin
			load_vaddr       = 1'b1;
			issue            = 1'b1;
			state_next.busy  = 1'b1;
			state_next.level = pgw_pkg::LVL_PML4;
		end else if (!state.busy) begin
			rsp.fault = 1'b1;
		end else if (state.level == pgw_pkg::LVL_PT) begin
			// last level: only an all-zero frame faults
			if (frame_4k == '0) begin
				rsp.fault = 1'b1;
			end else begin
				rsp.trans_addr = pgw_pkg::PA_W'({frame_4k, saved_vaddr[11:0]});
				rsp.map_size   = pgw_pkg::PAGE_4K;
			end
		end else if (!entry[pgw_pkg::PRESENT_BIT]) begin
			rsp.fault = 1'b1;
		end else if (state.level == pgw_pkg::LVL_PDPT && entry[pgw_pkg::PS_BIT]) begin
			rsp.trans_addr = {entry[51:30], saved_vaddr[29:0]};
			rsp.map_size   = pgw_pkg::PAGE_1G;
		end else if (state.level == pgw_pkg::LVL_PD && entry[pgw_pkg::PS_BIT]) begin
			rsp.trans_addr =
				pgw_pkg::PA_W'({entry[PHYS_TABLE_BITS-1:21], saved_vaddr[20:0]});
			rsp.map_size   = pgw_pkg::PAGE_2M;
		end else begin
			issue            = 1'b1;
			state_next.level = state.level + 2'd1;
		end

		// read issue, otherwise the walk ends
		if (issue) begin
			rsp.result_kind  = pgw_pkg::KIND_READ;
			rsp.read_address = rd_ext[pgw_pkg::RA_W-1:0];
		end else begin
			state_next.busy  = 1'b0;
			state_next.level = pgw_pkg::LVL_PML4;
		end
	end

endmodule

FILE: rtl/core/four_level_page_table_walker.sv
// top level of the four-level page table walker
`timescale 1ns / 1ps

// Four-level page table walker. Each request on req (a translate or a memory
// read response) produces exactly one result on rsp: either the address of the
// next entry to read or a finished walk (page, size or fault). One request is
// taken every cycle while rsp is not stalled; a request is held in the input
// register and its result in the result register, which offers it on rsp. The
// rate is set by the walk state (level, busy, saved address), which one request
// updates in the cycle it leaves the input register, ready for the next
// request behind it. The directory base is written over cfg, which is always
// ready; the user must write it only while no walk is in flight, as the block
// does not enforce this. Table and 4 KB page frames are bits PHYS_TABLE_BITS-1..12.
module four_level_page_table_walker #(
	parameter int PHYS_TABLE_BITS = pgw_pkg::PHYS_TABLE_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	pgw_req_if.sink  req,
	pgw_rsp_if.source rsp,
	pgw_cfg_if.sink  cfg
);

	logic                        valid_s1;
	logic                        op_s1;
	logic [pgw_pkg::VA_W-1:0]    va_s1;
	logic [pgw_pkg::ENTRY_W-1:0] entry_s1;
	logic                        err_s1;

	logic                        valid_s2;
	pgw_pkg::rsp_t               rsp_s2;

	pgw_pkg::walk_state_t        state_q;
	pgw_pkg::walk_state_t        state_next;
	logic [pgw_pkg::VA_W-1:0]    saved_vaddr_q;
	logic [pgw_pkg::DIR_W-1:0]   dir_base_q;

	pgw_pkg::rsp_t               rsp_next;
	logic                        load_vaddr;
	logic                        advance;

	// stage one moves on whenever the result register is free or drains
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1    <= req.operation;
			va_s1    <= req.virtual_address;
			entry_s1 <= req.entry_data;
			err_s1   <= req.read_error;
		end
	end

	// walk step logic
	pgw_step #(
		.PHYS_TABLE_BITS (PHYS_TABLE_BITS)
	) u_step (
		.operation       (op_s1),
		.virtual_address (va_s1),
		.entry_data      (entry_s1),
		.read_error      (err_s1),
		.state           (state_q),
		.saved_vaddr     (saved_vaddr_q),
		.dir_base        (dir_base_q),
		.state_next      (state_next),
		.load_vaddr      (load_vaddr),
		.rsp             (rsp_next)
	);

	// walk state and directory base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= '0;
			saved_vaddr_q <= '0;
			dir_base_q    <= '0;
		end else begin
			if (advance) begin
				state_q <= state_next;
				if (load_vaddr) begin
					saved_vaddr_q <= va_s1;
				end
			end
			if (cfg.valid && cfg.ready) begin
				dir_base_q <= cfg.data;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_next;
		end
	end

	// result outputs
	assign rsp.valid        = valid_s2;
	assign rsp.result_kind  = rsp_s2.result_kind;
	assign rsp.read_address = rsp_s2.read_address;
	assign rsp.trans_addr   = rsp_s2.trans_addr;
	assign rsp.map_size     = rsp_s2.map_size;
	assign rsp.fault        = rsp_s2.fault;

`ifndef SYNTHESIS
	// a translate leaves the walk busy at the top level
	a_translate_starts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == pgw_pkg::OP_TRANSLATE
		|=> state_q.busy && state_q.level == pgw_pkg::LVL_PML4)
		else $error("translate did not start a walk");

	// a finished walk leaves the walker idle
	a_done_idles: assert property (@(posedge clk) disable iff (!arst_n)
		advance && rsp_next.result_kind == pgw_pkg::KIND_DONE |=> !state_q.busy)
		else $error("walker still busy after finish");

	// a read issue never reports a fault or a page
	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.result_kind == pgw_pkg::KIND_READ
		|-> !rsp_s2.fault && rsp_s2.trans_addr == '0)
		else $error("read issue carries finish fields");

	// a fault carries no translation
	a_fault_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.fault
		|-> rsp_s2.trans_addr == '0 && rsp_s2.map_size == pgw_pkg::PAGE_4K
		&& rsp_s2.read_address == '0)
		else $error("fault carries translation fields");

	// page size code stays in range
	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> rsp_s2.map_size != 2'd3)
		else $error("page size code out of range");
`endif

endmodule

FILE: sim/four_level_page_table_walker_tb.sv
// self-checking testbench for the four-level page table walker
`timescale 1ns / 1ps

module four_level_page_table_walker_tb;

	localparam int          TBL_BITS       = pgw_pkg::PHYS_TABLE_BITS_DEF;
	localparam logic [63:0] ADDR_MASK      = (64'd1 << TBL_BITS) - 64'd1;
	localparam logic [63:0] TABLE_MASK     = ADDR_MASK & ~64'hfff;
	localparam logic [63:0] FRAME2M_MASK   = ADDR_MASK & ~64'h1f_ffff;
	localparam logic [63:0] FRAME1G_MASK   = 64'h000f_ffff_c000_0000;
	localparam int          STALL_LIMIT    = 2000;
	localparam int          RAND_PER_PHASE = 260;

	// one request as offered on the input channel
	typedef struct packed {
		logic                        operation;
		logic [pgw_pkg::VA_W-1:0]    virtual_address;
		logic [pgw_pkg::ENTRY_W-1:0] entry_data;
		logic                        read_error;
	} walk_req_t;

	logic clk;
	logic arst_n;

	pgw_req_if req_ch();
	pgw_rsp_if rsp_ch();
	pgw_cfg_if cfg_ch();

	four_level_page_table_walker u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// walk state mirrored by the predictor
	logic [pgw_pkg::DIR_W-1:0] dir_base_q;
	logic [pgw_pkg::LVL_W-1:0] walk_level;
	logic                      walk_busy;
	logic [pgw_pkg::VA_W-1:0]  saved_va;

	walk_req_t     walk_items[$];
	pgw_pkg::rsp_t results_due[$];

	int   items_queued   = 0;
	int   reqs_taken     = 0;
	int   results_seen   = 0;
	int   mismatch_count = 0;
	int   idle_cycles    = 0;
	int   hold_left      = 0;
	logic hold_done      = 1'b0;
	logic req_fire       = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// read of the entry for the given level of the open walk
	function automatic pgw_pkg::rsp_t entry_read(input logic [63:0] base,
		input logic [pgw_pkg::LVL_W-1:0] lvl);
		pgw_pkg::rsp_t o;
		logic [63:0]   idx;
		idx = (64'(saved_va) >> (39 - 9 * int'(lvl))) & 64'h1ff;
		walk_level = lvl;
		o = '0;
		o.result_kind  = pgw_pkg::KIND_READ;
		o.read_address = pgw_pkg::RA_W'((base + 64'd8 * idx) & ADDR_MASK);
		return o;
	endfunction

	// close the walk with a mapped page or a fault
	function automatic pgw_pkg::rsp_t walk_end(input logic flt, input logic [63:0] pa,
		input logic [pgw_pkg::SIZE_W-1:0] pg_size);
		pgw_pkg::rsp_t o;
		walk_busy  = 1'b0;
		walk_level = pgw_pkg::LVL_PML4;
		o = '0;
		o.result_kind = pgw_pkg::KIND_DONE;
		o.fault       = flt;
		if (!flt) begin
			o.trans_addr = pgw_pkg::PA_W'(pa);
			o.map_size   = pg_size;
		end
		return o;
	endfunction

	// expected result of one accepted request, advancing the walk state
	function automatic pgw_pkg::rsp_t predict_walk(input walk_req_t r);
		logic [63:0] ent;
		if (r.operation == pgw_pkg::OP_TRANSLATE) begin
			saved_va  = r.virtual_address;
			walk_busy = 1'b1;
			return entry_read(64'(dir_base_q) & ~64'hf, pgw_pkg::LVL_PML4);
		end
		if (!walk_busy)
			return walk_end(1'b1, '0, pgw_pkg::PAGE_4K);
		// a failed read reads as an empty entry
		ent = r.read_error ? '0 : r.entry_data;
		// leaf level only checks the frame, not the present bit
		if (walk_level == pgw_pkg::LVL_PT)
			return walk_end((ent & TABLE_MASK) == 64'd0,
				(ent & TABLE_MASK) + (64'(saved_va) & 64'hfff), pgw_pkg::PAGE_4K);
		if (!ent[pgw_pkg::PRESENT_BIT])
			return walk_end(1'b1, '0, pgw_pkg::PAGE_4K);
		if (walk_level == pgw_pkg::LVL_PDPT && ent[pgw_pkg::PS_BIT])
			return walk_end(1'b0, (ent & FRAME1G_MASK) + (64'(saved_va) & 64'h3fff_ffff),
				pgw_pkg::PAGE_1G);
		if (walk_level == pgw_pkg::LVL_PD && ent[pgw_pkg::PS_BIT])
			return walk_end(1'b0, (ent & FRAME2M_MASK) + (64'(saved_va) & 64'h1f_ffff),
				pgw_pkg::PAGE_2M);
		return entry_read(ent & TABLE_MASK, walk_level + 2'd1);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [pgw_pkg::VA_W-1:0] rand_va();
		return pgw_pkg::VA_W'({$urandom, $urandom});
	endfunction

	// present directory entry with random contents
	function automatic logic [63:0] table_entry(input logic big_page);
		logic [63:0] ent;
		ent = rand64();
		ent[pgw_pkg::PRESENT_BIT] = 1'b1;
		ent[pgw_pkg::PS_BIT]      = big_page;
		return ent;
	endfunction

	task automatic push_item(input logic op, input logic [pgw_pkg::VA_W-1:0] va,
		input logic [63:0] ent, input logic err);
		walk_items.push_back('{op, va, ent, err});
		items_queued++;
	endtask

	task automatic push_translate(input logic [pgw_pkg::VA_W-1:0] va);
		push_item(pgw_pkg::OP_TRANSLATE, va, rand64(), 1'($urandom_range(0, 1)));
	endtask

	task automatic push_entry(input logic [63:0] ent, input logic err);
		push_item(pgw_pkg::OP_RESPONSE, rand_va(), ent, err);
	endtask

	// mostly complete walks with random contents, some cut short, some stray responses
	task automatic random_walks(input int n);
		int          goal;
		int          pick;
		int          depth;
		logic        err;
		logic [63:0] ent;
		goal = items_queued + n;
		while (items_queued < goal) begin
			pick  = $urandom_range(0, 99);
			depth = $urandom_range(0, 3);
			if (pick < 85)
				push_translate(rand_va());
			if (pick < 30) begin
				// 4 KB page, leaf frame sometimes empty
				push_entry(table_entry(1'($urandom_range(0, 1))), 1'b0);
				push_entry(table_entry(1'b0), 1'b0);
				push_entry(table_entry(1'b0), 1'b0);
				ent = rand64();
				if ($urandom_range(0, 9) == 0)
					ent &= ~TABLE_MASK;
				push_entry(ent, 1'b0);
			end else if (pick < 45) begin
				// 1 GB page
				push_entry(table_entry(1'($urandom_range(0, 1))), 1'b0);
				push_entry(table_entry(1'b1), 1'b0);
			end else if (pick < 60) begin
				// 2 MB page
				push_entry(table_entry(1'($urandom_range(0, 1))), 1'b0);
				push_entry(table_entry(1'b0), 1'b0);
				push_entry(table_entry(1'b1), 1'b0);
			end else if (pick < 75) begin
				// fault at a random level, by a bad entry or a failed read
				repeat (depth) push_entry(table_entry(1'b0), 1'b0);
				err = ($urandom_range(0, 2) == 0);
				ent = rand64();
				if (!err) begin
					if (depth == 3)
						ent &= ~TABLE_MASK;
					else
						ent[pgw_pkg::PRESENT_BIT] = 1'b0;
				end
				push_entry(ent, err);
			end else if (pick < 85) begin
				// walk left open, the next translate replaces it
				repeat (depth % 3) push_entry(table_entry(1'b0), 1'b0);
			end else begin
				push_entry(rand64(), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// wait for all results, closing any open walk with a failed read
	task automatic settle_walks();
		do begin
			while (results_seen != items_queued)
				@(negedge clk);
			if (walk_busy)
				push_entry(rand64(), 1'b1);
		end while (results_seen != items_queued);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_dir_base(input logic [pgw_pkg::DIR_W-1:0] value);
		settle_walks();
		cfg_ch.data  <= value;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// request driver, fed from the queue of pending items
	always @(negedge clk) begin : p_drive
		walk_req_t nxt;
		if (arst_n && (!req_ch.valid || req_fire)) begin
			if (walk_items.size() != 0 &&
				((reqs_taken >= 350 && reqs_taken < 600) || $urandom_range(0, 99) >= 9)) begin
				nxt = walk_items.pop_front();
				req_ch.valid           <= 1'b1;
				req_ch.operation       <= nxt.operation;
				req_ch.virtual_address <= nxt.virtual_address;
				req_ch.entry_data      <= nxt.entry_data;
				req_ch.read_error      <= nxt.read_error;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result sink: random stalls, one long hold-off, one calm stretch
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else if (!hold_done && results_seen >= 200) begin
			hold_done    <= 1'b1;
			hold_left    <= 80;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= (results_seen >= 700 && results_seen < 950) ||
				$urandom_range(0, 99) >= 9;
		end
	end

	// monitor: predict on each request, check each result, watch for a hang
	always @(posedge clk) begin : p_monitor
		walk_req_t     taken;
		pgw_pkg::rsp_t want;
		req_fire <= arst_n && req_ch.valid && req_ch.ready;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				dir_base_q = cfg_ch.data;
			if (req_ch.valid && req_ch.ready) begin
				taken.operation       = req_ch.operation;
				taken.virtual_address = req_ch.virtual_address;
				taken.entry_data      = req_ch.entry_data;
				taken.read_error      = req_ch.read_error;
				results_due.push_back(predict_walk(taken));
				reqs_taken++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (results_due.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					want = results_due.pop_front();
					if (rsp_ch.result_kind !== want.result_kind)
						report_mismatch($sformatf("result %0d result_kind %h, expected %h",
							results_seen, rsp_ch.result_kind, want.result_kind));
					if (rsp_ch.read_address !== want.read_address)
						report_mismatch($sformatf("result %0d read_address %h, expected %h",
							results_seen, rsp_ch.read_address, want.read_address));
					if (rsp_ch.trans_addr !== want.trans_addr)
						report_mismatch($sformatf("result %0d trans_addr %h, expected %h",
							results_seen, rsp_ch.trans_addr, want.trans_addr));
					if (rsp_ch.map_size !== want.map_size)
						report_mismatch($sformatf("result %0d map_size %h, expected %h",
							results_seen, rsp_ch.map_size, want.map_size));
					if (rsp_ch.fault !== want.fault)
						report_mismatch($sformatf("result %0d fault %h, expected %h",
							results_seen, rsp_ch.fault, want.fault));
				end
				results_seen++;
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// stimulus sequence
	initial begin
		arst_n                 = 1'b0;
		req_ch.valid           = 1'b0;
		req_ch.operation       = pgw_pkg::OP_TRANSLATE;
		req_ch.virtual_address = '0;
		req_ch.entry_data      = '0;
		req_ch.read_error      = 1'b0;
		rsp_ch.ready           = 1'b0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.data            = '0;
		dir_base_q             = '0;
		walk_level             = pgw_pkg::LVL_PML4;
		walk_busy              = 1'b0;
		saved_va               = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed walks on the reset directory base
		push_entry(rand64(), 1'b0);                // response with no walk open
		push_translate('0);
		push_translate('1);                        // replaces the open walk
		push_entry(table_entry(1'b1), 1'b0);       // size bit ignored at the top level
		push_entry(table_entry(1'b0), 1'b0);
		push_entry(table_entry(1'b0), 1'b0);
		push_entry(64'hffff_ffff_ffff_fffe, 1'b0); // leaf present bit not checked
		push_translate(48'h0000_4000_0000);        // valid 1 GB mapping of address zero
		push_entry(table_entry(1'b0), 1'b0);
		push_entry(64'h81, 1'b0);
		push_translate(rand_va());
		push_entry(table_entry(1'b0), 1'b0);
		push_entry('1, 1'b0);                      // 1 GB frame from the top bits
		push_translate(rand_va());
		push_entry(table_entry(1'b0), 1'b0);
		push_entry(table_entry(1'b0), 1'b0);
		push_entry('1, 1'b0);                      // 2 MB frame, low flag bits dropped
		push_translate(rand_va());
		push_entry(table_entry(1'b0), 1'b0);
		push_entry(table_entry(1'b0), 1'b0);
		push_entry(table_entry(1'b0), 1'b0);
		push_entry(64'h0fff, 1'b0);                // leaf with an empty frame
		push_translate(rand_va());
		push_entry(table_entry(1'b0), 1'b0);
		push_entry(table_entry(1'b0), 1'b0);
		push_entry(table_entry(1'b0), 1'b0);
		push_entry('1, 1'b1);                      // failed leaf read

		// top of the address space: first read address wraps
		write_dir_base('1);
		push_translate('1);
		push_entry(table_entry(1'b0), 1'b1);
		random_walks(RAND_PER_PHASE);

		write_dir_base(pgw_pkg::DIR_W'({$urandom, $urandom}));
		random_walks(RAND_PER_PHASE);

		write_dir_base(pgw_pkg::DIR_W'({$urandom, $urandom}) | pgw_pkg::DIR_W'(4'hf));
		random_walks(RAND_PER_PHASE);

		write_dir_base('0);
		random_walks(RAND_PER_PHASE);

		settle_walks();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
